/* rtl/core/counting_semaphore_bank_core_macros.svh */
// assertion helpers shared by the semaphore bank rtl
`ifndef COUNTING_SEMAPHORE_BANK_CORE_MACROS_SVH
`define COUNTING_SEMAPHORE_BANK_CORE_MACROS_SVH

// same-cycle implication, silenced during reset
`define CSB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, silenced during reset
`define CSB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/csb_pkg.sv */
package csb_pkg;

  // default sizes of the bank
  localparam int NUM_SEMS_DEF   = 16;
  localparam int WAIT_DEPTH_DEF = 8;
  localparam int PID_BITS_DEF   = 16;

  // command queue between front and back
  localparam int CMD_DEPTH = 2;

  // stream widths
  localparam int IN_W  = 40;
  localparam int OUT_W = 40;

  // operation codes
  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_WAIT  = 2'd1;
  localparam logic [1:0] OP_POST  = 2'd2;
  localparam logic [1:0] OP_CLOSE = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BLOCKED  = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_INACTIVE = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_SAT      = 3'd5;

  // saturation limits
  localparam logic [14:0] COUNT_MAX = 15'h7fff;
  localparam logic [7:0]  CONN_MAX  = 8'hff;

  // classified command as it waits in the queue
  typedef struct packed {
    logic [1:0]  op;
    logic        bad_index;
    logic        negative;
    logic [3:0]  sem_index;
    logic [15:0] caller_pid;
    logic [14:0] init_count;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic [14:0] count_after;
    logic [15:0] woken_pid;
    logic        woken_valid;
    logic [2:0]  status;
  } res_t;

endpackage

/* rtl/core/counting_semaphore_bank_core.sv */
// counting semaphore bank: open, wait, post and close on indexed slots
// the back end pops a new command only when idle, once the read-modify-write of the slot
//   record memory and, for a post that wakes a waiter, the extra read of the waiter memory
//   are done; the command queue can still take beats meanwhile
// reset: synchronous; clears the command queue, sequencer, result valid and all active
//   flags; record and waiter memories are not swept
`include "counting_semaphore_bank_core_macros.svh"

module counting_semaphore_bank_core #(
  parameter int NUM_SEMS   = csb_pkg::NUM_SEMS_DEF,
  parameter int WAIT_DEPTH = csb_pkg::WAIT_DEPTH_DEF,
  parameter int PID_BITS   = csb_pkg::PID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // operation[1:0], sem_index[5:2], caller_pid[21:6], init_value[37:22], zero[39:38]
  input  logic [csb_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // status[2:0], woken_valid[3], woken_pid[19:4], count_after[34:20], zero[39:35]
  output logic [csb_pkg::OUT_W-1:0] m_axis_tdata
);

  csb_pkg::cmd_t front_cmd;
  csb_pkg::cmd_t queue_cmd;
  csb_pkg::res_t res;
  logic          cmd_full;
  logic          cmd_empty;
  logic          cmd_pop;

  // classify incoming beats
  csb_front #(
    .NUM_SEMS(NUM_SEMS)
  ) u_front (
    .tdata(s_axis_tdata),
    .cmd  (front_cmd)
  );

  // short queue decoupling front and back
  csb_cmd_fifo u_cmd_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (s_axis_tvalid),
    .din  (front_cmd),
    .full (cmd_full),
    .pop  (cmd_pop),
    .dout (queue_cmd),
    .empty(cmd_empty)
  );

  assign s_axis_tready = !cmd_full;

  // carry out commands on the slot state
  csb_back #(
    .NUM_SEMS  (NUM_SEMS),
    .WAIT_DEPTH(WAIT_DEPTH),
    .PID_BITS  (PID_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(!cmd_empty),
    .cmd      (queue_cmd),
    .cmd_pop  (cmd_pop),
    .res_ready(m_axis_tready),
    .res_valid(m_axis_tvalid),
    .res      (res)
  );

  // pack the result beat
  assign m_axis_tdata = {5'd0, res.count_after, res.woken_pid, res.woken_valid, res.status};

  // checks
  `CSB_ASSERT_IMP(a_no_pop_empty, clk, rst, cmd_empty, !cmd_pop, "pop from empty command queue")
  `CSB_ASSERT_NXT(a_no_back_to_back_pop, clk, rst, cmd_pop, !cmd_pop, "back popped twice in a row")
  `CSB_ASSERT_IMP(a_woken_ok, clk, rst, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[2:0] == csb_pkg::ST_OK, "waking result without ok status")
  `CSB_ASSERT_IMP(a_pid_zero, clk, rst, m_axis_tvalid && !m_axis_tdata[3], m_axis_tdata[19:4] == 16'd0, "woken pid set without a wake")

endmodule

/* rtl/core/csb_ram.sv */
module csb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/csb_front.sv */
module csb_front #(
  parameter int NUM_SEMS = csb_pkg::NUM_SEMS_DEF
) (
  input  logic [csb_pkg::IN_W-1:0] tdata,
  output csb_pkg::cmd_t            cmd
);

  logic [3:0]  sem_index;
  logic [15:0] init_value;

  assign sem_index  = tdata[5:2];
  assign init_value = tdata[37:22];

  // split the beat and flag out-of-bank slots and negative initial counts
  always_comb begin
    cmd.op         = tdata[1:0];
    cmd.sem_index  = sem_index;
    cmd.caller_pid = tdata[21:6];
    cmd.init_count = init_value[14:0];
    cmd.negative   = init_value[15];
    cmd.bad_index  = ({5'd0, sem_index} >= 9'(NUM_SEMS));
  end

endmodule

/* rtl/core/csb_cmd_fifo.sv */
module csb_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  csb_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output csb_pkg::cmd_t dout,
  output logic          empty
);

  localparam int PW = (csb_pkg::CMD_DEPTH > 1) ? $clog2(csb_pkg::CMD_DEPTH) : 1;

  csb_pkg::cmd_t entry [csb_pkg::CMD_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   fill;

  assign full  = (fill == (PW+1)'(csb_pkg::CMD_DEPTH));
  assign empty = (fill == '0);
  assign dout  = entry[rptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/core/csb_back.sv */
module csb_back #(
  parameter int NUM_SEMS   = csb_pkg::NUM_SEMS_DEF,
  parameter int WAIT_DEPTH = csb_pkg::WAIT_DEPTH_DEF,
  parameter int PID_BITS   = csb_pkg::PID_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  csb_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_ready,
  output logic          res_valid,
  output csb_pkg::res_t res
);

  localparam int SLOT_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int PTR_W   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int FILL_W  = $clog2(WAIT_DEPTH + 1);
  localparam int CNT_W   = 15;
  localparam int CONN_W  = 8;
  localparam int REC_W   = CNT_W + CONN_W + 2 * PTR_W + FILL_W;
  localparam int WQ_DEPTH = 1 << (SLOT_W + PTR_W);
  localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(WAIT_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(WAIT_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAKE = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  csb_pkg::cmd_t       cur;
  logic [NUM_SEMS-1:0] slot_active;

  logic [SLOT_W-1:0]   pop_slot;
  logic [SLOT_W-1:0]   cur_slot;
  logic [REC_W-1:0]    rec_rdata;
  logic [REC_W-1:0]    rec_wdata;
  logic                rec_we;
  logic [PID_BITS-1:0] wq_rdata;
  logic [PID_BITS-1:0] wq_wdata;
  logic                wq_we;
  logic                wq_re;
  logic [PTR_W-1:0]    wq_ptr;

  logic [CNT_W-1:0]    r_count;
  logic [CONN_W-1:0]   r_conn;
  logic [PTR_W-1:0]    r_head;
  logic [PTR_W-1:0]    r_tail;
  logic [FILL_W-1:0]   r_fill;
  logic [CNT_W-1:0]    n_count;
  logic [CONN_W-1:0]   n_conn;
  logic [PTR_W-1:0]    n_head;
  logic [PTR_W-1:0]    n_tail;
  logic [FILL_W-1:0]   n_fill;

  logic                act;
  logic                act_set;
  logic                act_clr;
  logic                out_free;
  logic                finish;
  csb_pkg::res_t       res_next;

  // slot index of a command, slot zero when outside the bank
  always_comb begin
    pop_slot = '0;
    cur_slot = '0;
    for (int i = 0; i < SLOT_W; i++) begin
      if (i < 4) begin
        pop_slot[i] = cmd.sem_index[i] & !cmd.bad_index;
        cur_slot[i] = cur.sem_index[i] & !cur.bad_index;
      end
    end
  end

  // caller pid narrowed or widened to the stored width
  always_comb begin
    wq_wdata = '0;
    for (int i = 0; i < PID_BITS; i++) begin
      if (i < 16) begin
        wq_wdata[i] = cur.caller_pid[i];
      end
    end
  end

  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign out_free = !res_valid || res_ready;
  assign act      = slot_active[cur_slot];
  assign {r_count, r_conn, r_head, r_tail, r_fill} = rec_rdata;
  assign rec_wdata = {n_count, n_conn, n_head, n_tail, n_fill};

  // per-slot record: count, connections, queue pointers and fill
  csb_ram #(
    .WIDTH(REC_W),
    .DEPTH(NUM_SEMS)
  ) u_rec_ram (
    .clk  (clk),
    .we   (rec_we),
    .waddr(cur_slot),
    .wdata(rec_wdata),
    .re   (cmd_pop),
    .raddr(pop_slot),
    .rdata(rec_rdata)
  );

  // waiter pids, one row of queue entries per slot
  csb_ram #(
    .WIDTH(PID_BITS),
    .DEPTH(WQ_DEPTH)
  ) u_wait_ram (
    .clk  (clk),
    .we   (wq_we),
    .waddr({cur_slot, r_tail}),
    .wdata(wq_wdata),
    .re   (wq_re),
    .raddr({cur_slot, wq_ptr}),
    .rdata(wq_rdata)
  );

  assign wq_ptr = r_head;

  // execute the command against the slot record
  always_comb begin
    n_count    = r_count;
    n_conn     = r_conn;
    n_head     = r_head;
    n_tail     = r_tail;
    n_fill     = r_fill;
    rec_we     = 1'b0;
    act_set    = 1'b0;
    act_clr    = 1'b0;
    wq_we      = 1'b0;
    wq_re      = 1'b0;
    finish     = 1'b0;
    state_next = state;
    res_next   = '0;
    res_next.status = csb_pkg::ST_OK;

    unique case (state)
      S_IDLE: begin
        if (cmd_pop) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
          if (cur.bad_index) begin
            res_next.status = csb_pkg::ST_INVALID;
          end else if (cur.op == csb_pkg::OP_OPEN) begin
            if (cur.negative) begin
              res_next.status      = csb_pkg::ST_INVALID;
              res_next.count_after = act ? r_count : '0;
            end else if (!act) begin
              act_set = 1'b1;
              rec_we  = 1'b1;
              n_count = cur.init_count;
              n_conn  = CONN_W'(1);
              n_head  = '0;
              n_tail  = '0;
              n_fill  = '0;
              res_next.count_after = cur.init_count;
            end else begin
              if (r_conn != csb_pkg::CONN_MAX) begin
                n_conn = r_conn + 1'b1;
                rec_we = 1'b1;
              end
              res_next.count_after = r_count;
            end
          end else if (!act) begin
            res_next.status = csb_pkg::ST_INACTIVE;
          end else begin
            case (cur.op)
              csb_pkg::OP_WAIT: begin
                if (r_count != '0) begin
                  n_count = r_count - 1'b1;
                  rec_we  = 1'b1;
                end else if (r_fill >= FULL_FILL) begin
                  res_next.status = csb_pkg::ST_FULL;
                end else begin
                  // queue the caller at the tail
                  wq_we   = 1'b1;
                  n_tail  = (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;
                  n_fill  = r_fill + 1'b1;
                  rec_we  = 1'b1;
                  res_next.status = csb_pkg::ST_BLOCKED;
                end
                res_next.count_after = n_count;
              end
              csb_pkg::OP_POST: begin
                if (r_fill != '0) begin
                  // fetch the oldest waiter first
                  finish     = 1'b0;
                  wq_re      = 1'b1;
                  state_next = S_WAKE;
                end else if (r_count >= csb_pkg::COUNT_MAX) begin
                  res_next.status = csb_pkg::ST_SAT;
                end else begin
                  n_count = r_count + 1'b1;
                  rec_we  = 1'b1;
                end
                res_next.count_after = n_count;
              end
              default: begin
                if (r_conn <= CONN_W'(1)) begin
                  act_clr = 1'b1;
                end else begin
                  n_conn = r_conn - 1'b1;
                  rec_we = 1'b1;
                  res_next.count_after = r_count;
                end
              end
            endcase
          end
        end
      end
      S_WAKE: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
          rec_we     = 1'b1;
          n_head     = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
          n_fill     = r_fill - 1'b1;
          res_next.woken_valid = 1'b1;
          res_next.count_after = r_count;
          for (int i = 0; i < 16; i++) begin
            if (i < PID_BITS) begin
              res_next.woken_pid[i] = wq_rdata[i];
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // latch the popped command
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  // sequencer, active flags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_active <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (act_set) begin
        slot_active[cur_slot] <= 1'b1;
      end
      if (act_clr) begin
        slot_active[cur_slot] <= 1'b0;
      end
      if (finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (finish) begin
      res <= res_next;
    end
  end

endmodule

/* test/counting_semaphore_bank_core_tb.sv */
`timescale 1ns / 1ps

module counting_semaphore_bank_core_tb;

  localparam int SLOTS      = csb_pkg::NUM_SEMS_DEF;
  localparam int DEPTH      = csb_pkg::WAIT_DEPTH_DEF;
  localparam int TIMEOUT_NS = 20_000_000;

  // one request as it sits in s_axis_tdata, op in the lowest bits
  typedef struct packed {
    logic [15:0] init_value;
    logic [15:0] caller_pid;
    logic [3:0]  sem_index;
    logic [1:0]  op;
  } sem_req_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [csb_pkg::IN_W-1:0]  s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [csb_pkg::OUT_W-1:0] m_axis_tdata;

  // shadow copy of the semaphore bank
  bit          slot_active [SLOTS];
  logic [14:0] sem_count   [SLOTS];
  logic [7:0]  conn_count  [SLOTS];
  logic [15:0] waiters     [SLOTS][DEPTH];
  logic [2:0]  wq_head     [SLOTS];
  logic [2:0]  wq_tail     [SLOTS];
  logic [3:0]  wq_fill     [SLOTS];

  csb_pkg::res_t pending_replies[$];
  csb_pkg::res_t seen_reply, due_reply;
  int   errors = 0;

  // traffic shaping shared with the receiver process
  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;
  int hold_cycles = 0;
  bit rx_holding = 1'b0;

  counting_semaphore_bank_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // drop a slot and all of its waiters
  function automatic void free_slot(input logic [3:0] s);
    slot_active[s] = 1'b0;
    sem_count[s]   = '0;
    conn_count[s]  = '0;
    wq_head[s]     = '0;
    wq_tail[s]     = '0;
    wq_fill[s]     = '0;
  endfunction

  // update the shadow bank for one request and return the reply it earns
  function automatic csb_pkg::res_t apply_sem_op(input sem_req_t req);
    csb_pkg::res_t r;
    logic [3:0]    s;
    r = '0;
    s = req.sem_index;
    if (req.op == csb_pkg::OP_OPEN) begin
      if (req.init_value[15]) begin
        r.status = csb_pkg::ST_INVALID;
      end else if (!slot_active[s]) begin
        slot_active[s] = 1'b1;
        sem_count[s]   = req.init_value[14:0];
        conn_count[s]  = 8'd1;
        wq_head[s]     = '0;
        wq_tail[s]     = '0;
        wq_fill[s]     = '0;
      end else if (conn_count[s] != csb_pkg::CONN_MAX) begin
        conn_count[s] = conn_count[s] + 8'd1;
      end
      r.count_after = sem_count[s];
    end else if (!slot_active[s]) begin
      r.status = csb_pkg::ST_INACTIVE;
    end else begin
      case (req.op)
        csb_pkg::OP_WAIT: begin
          if (sem_count[s] != '0) begin
            sem_count[s] = sem_count[s] - 15'd1;
          end else if (wq_fill[s] == 4'(DEPTH)) begin
            r.status = csb_pkg::ST_FULL;
          end else begin
            waiters[s][wq_tail[s]] = req.caller_pid;
            wq_tail[s] = wq_tail[s] + 3'd1;
            wq_fill[s] = wq_fill[s] + 4'd1;
            r.status   = csb_pkg::ST_BLOCKED;
          end
        end
        csb_pkg::OP_POST: begin
          if (wq_fill[s] != '0) begin
            r.woken_valid = 1'b1;
            r.woken_pid   = waiters[s][wq_head[s]];
            wq_head[s]    = wq_head[s] + 3'd1;
            wq_fill[s]    = wq_fill[s] - 4'd1;
          end else if (sem_count[s] == csb_pkg::COUNT_MAX) begin
            r.status = csb_pkg::ST_SAT;
          end else begin
            sem_count[s] = sem_count[s] + 15'd1;
          end
        end
        default: begin
          if (conn_count[s] <= 8'd1) free_slot(s);
          else conn_count[s] = conn_count[s] - 8'd1;
        end
      endcase
      r.count_after = sem_count[s];
    end
    return r;
  endfunction

  // offer one request beat after a random gap and predict its reply on acceptance
  task automatic send_request(input logic [1:0] op, input logic [3:0] idx,
                              input logic [15:0] pid, input logic [15:0] init);
    int       gap;
    sem_req_t req;
    gap = tx_eager ? 0 : $urandom_range(0, 15);
    req.op         = op;
    req.sem_index  = idx;
    req.caller_pid = pid;
    req.init_value = init;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, req};
    do @(posedge clk); while (!s_axis_tready);
    pending_replies.push_back(apply_sem_op(req));
  endtask

  task automatic idle_sender();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic flag_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // edge cases: inactive slots, negative init, full queue, saturation, free with waiters
  task automatic test_directed_cases();
    int i;
    send_request(csb_pkg::OP_WAIT, 4'd0, 16'd1, 16'd0);
    send_request(csb_pkg::OP_POST, 4'd1, 16'd0, 16'd0);
    send_request(csb_pkg::OP_CLOSE, 4'd2, 16'd0, 16'd0);
    send_request(csb_pkg::OP_OPEN, 4'd0, 16'd0, 16'h8000);
    send_request(csb_pkg::OP_OPEN, 4'd0, 16'd0, 16'd0);
    send_request(csb_pkg::OP_OPEN, 4'd0, 16'd0, 16'hffff);
    for (i = 0; i < DEPTH; i++) begin
      send_request(csb_pkg::OP_WAIT, 4'd0,
                   (i == 0) ? 16'hffff : (i == 1) ? 16'h0000 : 16'($urandom),
                   16'($urandom));
    end
    send_request(csb_pkg::OP_WAIT, 4'd0, 16'h1234, 16'd0);
    send_request(csb_pkg::OP_POST, 4'd0, 16'd0, 16'd0);
    send_request(csb_pkg::OP_POST, 4'd0, 16'd0, 16'd0);
    send_request(csb_pkg::OP_CLOSE, 4'd0, 16'd0, 16'd0);
    // reopened slot starts with an empty queue
    send_request(csb_pkg::OP_OPEN, 4'd0, 16'd0, 16'd3);
    send_request(csb_pkg::OP_WAIT, 4'd0, 16'h00aa, 16'd0);
    // count at its ceiling
    send_request(csb_pkg::OP_OPEN, 4'd15, 16'd0, 16'h7fff);
    send_request(csb_pkg::OP_POST, 4'd15, 16'd0, 16'd0);
    send_request(csb_pkg::OP_WAIT, 4'd15, 16'd0, 16'd0);
    send_request(csb_pkg::OP_POST, 4'd15, 16'd0, 16'd0);
    send_request(csb_pkg::OP_OPEN, 4'd15, 16'd0, 16'd5);
    send_request(csb_pkg::OP_CLOSE, 4'd15, 16'd0, 16'd0);
    send_request(csb_pkg::OP_CLOSE, 4'd15, 16'd0, 16'd0);
    send_request(csb_pkg::OP_CLOSE, 4'd15, 16'd0, 16'd0);
  endtask

  // connection count pinned at its limit, then unwound to a free slot
  task automatic test_connection_limit();
    repeat (258) send_request(csb_pkg::OP_OPEN, 4'd7, 16'($urandom), 16'd100);
    repeat (256) send_request(csb_pkg::OP_CLOSE, 4'd7, 16'($urandom), 16'($urandom));
  endtask

  // mostly live slots with random content, traffic shaping changed every 100 beats
  task automatic test_random_traffic(input int n_items);
    int          i, r;
    logic [1:0]  op;
    logic [3:0]  idx;
    logic [15:0] init;
    for (i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        tx_eager = ($urandom_range(0, 3) == 0);
        rx_eager = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 15) op = csb_pkg::OP_OPEN;
      else if (r < 60) op = csb_pkg::OP_WAIT;
      else if (r < 90) op = csb_pkg::OP_POST;
      else op = csb_pkg::OP_CLOSE;
      idx = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      r = $urandom_range(0, 9);
      if (r < 6) init = 16'($urandom_range(0, 2));
      else if (r < 8) init = 16'($urandom_range(0, 32767));
      else if (r < 9) init = 16'h7fff - 16'($urandom_range(0, 1));
      else init = 16'($urandom);
      send_request(op, idx, 16'($urandom), init);
    end
    tx_eager = 1'b0;
    rx_eager = 1'b0;
  endtask

  // receiver holds off for a long stretch while requests keep coming back to back
  task automatic test_output_stall();
    idle_sender();
    hold_cycles = 400;
    wait (rx_holding);
    tx_eager = 1'b1;
    send_request(csb_pkg::OP_OPEN, 4'd1, 16'd0, 16'd2);
    repeat (40) begin
      send_request($urandom_range(0, 1) ? csb_pkg::OP_WAIT : csb_pkg::OP_POST, 4'd1,
                   16'($urandom), 16'($urandom));
    end
    tx_eager = 1'b0;
  endtask

  // receiver: random stall per beat, or a long hold-off when one is requested
  initial begin
    int stall;
    wait (rst == 1'b0);
    @(negedge clk);
    m_axis_tready <= 1'b1;
    forever begin
      if (hold_cycles > 0) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
        rx_holding = 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        rx_holding  = 1'b0;
        m_axis_tready <= 1'b1;
      end else begin
        stall = rx_eager ? 0 : $urandom_range(0, 15);
        if (stall > 0) begin
          @(negedge clk);
          m_axis_tready <= 1'b0;
          repeat (stall) @(negedge clk);
          m_axis_tready <= 1'b1;
        end
      end
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready) && hold_cycles == 0);
    end
  end

  // compare each reply beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_reply = csb_pkg::res_t'(m_axis_tdata[34:0]);
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: reply beat with no request outstanding", $time);
      end else begin
        due_reply = pending_replies.pop_front();
        flag_field("status", due_reply.status, seen_reply.status);
        flag_field("woken_valid", due_reply.woken_valid, seen_reply.woken_valid);
        flag_field("woken_pid", due_reply.woken_pid, seen_reply.woken_pid);
        flag_field("count_after", due_reply.count_after, seen_reply.count_after);
      end
    end
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  // reset, test sequence and final verdict
  initial begin
    int s;
    for (s = 0; s < SLOTS; s++) free_slot(4'(s));
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_connection_limit();
    test_random_traffic(1300);
    test_output_stall();

    idle_sender();
    wait (pending_replies.size() == 0);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/csb_pkg.sv
rtl/core/csb_ram.sv
rtl/core/csb_front.sv
rtl/core/csb_cmd_fifo.sv
rtl/core/csb_back.sv
rtl/core/counting_semaphore_bank_core.sv
test/counting_semaphore_bank_core_tb.sv
